>>> hdl/swt_pkg.sv
// Shared constants, verdict codes and event type for the sequence window tracker.
package swt_pkg;

   localparam int WINDOW_BITS_DEFAULT = 64;
   localparam int SEQ_W               = 32;
   localparam int GAP_W               = 31;
   localparam int COUNT_W             = 64;
   localparam int VERDICT_W           = 3;
   localparam int REQ_DATA_W          = 32;
   localparam int REQ_USER_W          = 1;
   localparam int RSP_DATA_W          = 288;
   localparam int RSP_USER_W          = 3;

   localparam logic [VERDICT_W-1:0] VERDICT_FIRST     = 3'd0;
   localparam logic [VERDICT_W-1:0] VERDICT_NEWEST    = 3'd1;
   localparam logic [VERDICT_W-1:0] VERDICT_LATE_FILL = 3'd2;
   localparam logic [VERDICT_W-1:0] VERDICT_DUPLICATE = 3'd3;
   localparam logic [VERDICT_W-1:0] VERDICT_TOO_OLD   = 3'd4;

   // Outcome of classifying one sequence number, passed to the counters.
   typedef struct packed {
      logic [VERDICT_W-1:0] verdict;
      logic [GAP_W-1:0]     gap_lost;
      logic                 inc_unique;
      logic                 inc_duplicate;
      logic                 inc_late;
   } swt_event_type;

endpackage

>>> hdl/swt_window.sv
// Highest-sequence register, seen bitmap and classification of each number.
module swt_window #(
   parameter int WINDOW_BITS = swt_pkg::WINDOW_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  logic [swt_pkg::SEQ_W-1:0]  seq_number,
   input  logic                       restart,
   output swt_pkg::swt_event_type     event_out
);
   import swt_pkg::*;

   localparam int IDX_W = $clog2(WINDOW_BITS);

   logic                   tracker_valid_ff;
   logic [SEQ_W-1:0]       highest_seq_ff, highest_seq_in;
   logic [WINDOW_BITS-1:0] seen_window_ff, seen_window_in;

   logic             live;
   logic [SEQ_W-1:0] diff;
   logic [SEQ_W-1:0] age;
   logic             newer;
   logic             seen_bit;

   always_comb begin
      live     = tracker_valid_ff & ~restart;
      diff     = seq_number - highest_seq_ff;
      age      = highest_seq_ff - seq_number;
      newer    = (diff != '0) && !diff[SEQ_W-1];
      seen_bit = seen_window_ff[age[IDX_W-1:0]];

      highest_seq_in = highest_seq_ff;
      seen_window_in = seen_window_ff;
      event_out      = '0;

      if (!live) begin
         highest_seq_in       = seq_number;
         seen_window_in       = WINDOW_BITS'(1);
         event_out.verdict    = VERDICT_FIRST;
         event_out.inc_unique = 1'b1;
      end else if (newer) begin
         highest_seq_in = seq_number;
         // shifting the fixed-width bitmap drops bits beyond the window
         if (diff < SEQ_W'(WINDOW_BITS))
            seen_window_in = (seen_window_ff << diff[IDX_W-1:0]) | WINDOW_BITS'(1);
         else
            seen_window_in = WINDOW_BITS'(1);
         event_out.verdict    = VERDICT_NEWEST;
         event_out.gap_lost   = diff[GAP_W-1:0] - GAP_W'(1);
         event_out.inc_unique = 1'b1;
      end else if (age < SEQ_W'(WINDOW_BITS)) begin
         if (seen_bit) begin
            event_out.verdict       = VERDICT_DUPLICATE;
            event_out.inc_duplicate = 1'b1;
         end else begin
            seen_window_in       = seen_window_ff | (WINDOW_BITS'(1) << age[IDX_W-1:0]);
            event_out.verdict    = VERDICT_LATE_FILL;
            event_out.inc_unique = 1'b1;
            event_out.inc_late   = 1'b1;
         end
      end else begin
         event_out.verdict  = VERDICT_TOO_OLD;
         event_out.inc_late = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tracker_valid_ff <= 1'b0;
      end else if (step) begin
         tracker_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         highest_seq_ff <= highest_seq_in;
         seen_window_ff <= seen_window_in;
      end
   end

endmodule

>>> hdl/swt_counters.sv
// Four wrapping 64-bit statistics counters, updated once per classified word.
module swt_counters (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step,
   input  swt_pkg::swt_event_type       event_in,
   output logic [swt_pkg::COUNT_W-1:0]  unique_total,
   output logic [swt_pkg::COUNT_W-1:0]  lost_total,
   output logic [swt_pkg::COUNT_W-1:0]  duplicate_total,
   output logic [swt_pkg::COUNT_W-1:0]  late_total
);
   import swt_pkg::*;

   logic [COUNT_W-1:0] unique_ff, unique_in;
   logic [COUNT_W-1:0] lost_ff, lost_in;
   logic [COUNT_W-1:0] duplicate_ff, duplicate_in;
   logic [COUNT_W-1:0] late_ff, late_in;

   always_comb begin
      unique_in    = unique_ff + COUNT_W'(event_in.inc_unique);
      lost_in      = lost_ff + COUNT_W'(event_in.gap_lost);
      duplicate_in = duplicate_ff + COUNT_W'(event_in.inc_duplicate);
      late_in      = late_ff + COUNT_W'(event_in.inc_late);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unique_ff    <= '0;
         lost_ff      <= '0;
         duplicate_ff <= '0;
         late_ff      <= '0;
      end else if (step) begin
         unique_ff    <= unique_in;
         lost_ff      <= lost_in;
         duplicate_ff <= duplicate_in;
         late_ff      <= late_in;
      end
   end

   // counters only move when the result register loads, so they double as it
   assign unique_total    = unique_ff;
   assign lost_total      = lost_ff;
   assign duplicate_total = duplicate_ff;
   assign late_total      = late_ff;

endmodule

>>> hdl/sequence_window_tracker.sv
// Sequence window tracker: loss, duplicate and reordering check on packet numbers.
//
// req channel: one word per packet, req_tdata = 32-bit sequence number,
// req_tuser = restart flag (clears the tracker, keeps the counters).
// rsp channel: one word per request, rsp_tuser = verdict, rsp_tdata =
// gap_lost and the four running totals as they stand after that packet.
// Pipeline: an accepted request is held in the input register, then classified
// and counted into the result stage, which drives the response.
// Throughput: one word per cycle while rsp_tready is high; the only loop is the tracker state
// (highest number and seen bitmap) and the counters, which all update on the same step.
// Reset: synchronous; empties both stages, clears the tracker and the
// counters. The first word afterwards starts the tracker.
// Stall: when rsp_tready is low the response holds, one more request may sit
// in the input register, then req_tready drops. Nothing is lost or repeated.
module sequence_window_tracker #(
   parameter int WINDOW_BITS = swt_pkg::WINDOW_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [swt_pkg::REQ_DATA_W-1:0]   req_tdata,  // [31:0] seq_number
   input  logic [swt_pkg::REQ_USER_W-1:0]   req_tuser,  // [0] restart
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [30:0] gap_lost, [94:31] unique_total, [158:95] lost_total,
   // [222:159] duplicate_total, [286:223] late_total, [287] zero
   output logic [swt_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic [swt_pkg::RSP_USER_W-1:0]   rsp_tuser   // [2:0] verdict
);
   import swt_pkg::*;

   logic                 in_valid_ff;
   logic [SEQ_W-1:0]     in_seq_ff;
   logic                 in_restart_ff;
   logic                 out_valid_ff;
   logic [VERDICT_W-1:0] verdict_ff;
   logic [GAP_W-1:0]     gap_ff;

   logic                 step;
   logic                 req_take;
   swt_event_type        item_event;
   logic [COUNT_W-1:0]   unique_total, lost_total, duplicate_total, late_total;

   assign step       = in_valid_ff & (~out_valid_ff | rsp_tready);
   assign req_tready = ~in_valid_ff | step;
   assign req_take   = req_tvalid & req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready)
            in_valid_ff <= req_tvalid;
         if (~out_valid_ff | rsp_tready)
            out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_seq_ff     <= req_tdata[SEQ_W-1:0];
         in_restart_ff <= req_tuser[0];
      end
      if (step) begin
         verdict_ff <= item_event.verdict;
         gap_ff     <= item_event.gap_lost;
      end
   end

   swt_window #(
      .WINDOW_BITS (WINDOW_BITS)
   ) u_window (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .seq_number (in_seq_ff),
      .restart    (in_restart_ff),
      .event_out  (item_event)
   );

   swt_counters u_counters (
      .clock           (clock),
      .reset           (reset),
      .step            (step),
      .event_in        (item_event),
      .unique_total    (unique_total),
      .lost_total      (lost_total),
      .duplicate_total (duplicate_total),
      .late_total      (late_total)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = verdict_ff;
   assign rsp_tdata  = {1'b0, late_total, duplicate_total, lost_total, unique_total, gap_ff};

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the sequence window tracker: directed and random packet streams.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import swt_pkg::*;

   localparam int WIN       = WINDOW_BITS_DEFAULT;
   localparam int WIN_IDX_W = $clog2(WIN);

   typedef struct {
      logic [VERDICT_W-1:0] verdict;
      logic [GAP_W-1:0]     gap_lost;
      logic [COUNT_W-1:0]   unique_total;
      logic [COUNT_W-1:0]   lost_total;
      logic [COUNT_W-1:0]   dup_total;
      logic [COUNT_W-1:0]   late_total;
   } pkt_outcome_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // [31:0] seq_number
   logic [REQ_USER_W-1:0] req_tuser = '0;   // [0] restart
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [30:0] gap_lost, [94:31] unique_total, [158:95] lost_total,
   // [222:159] duplicate_total, [286:223] late_total, [287] zero
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;        // [2:0] verdict

   // tracker model state
   logic                  trk_valid = 1'b0;
   logic [SEQ_W-1:0]      trk_highest = '0;
   logic [WIN-1:0]        trk_seen = '0;
   logic [COUNT_W-1:0]    n_unique = '0;
   logic [COUNT_W-1:0]    n_lost = '0;
   logic [COUNT_W-1:0]    n_dup = '0;
   logic [COUNT_W-1:0]    n_late = '0;

   pkt_outcome_type pending_outcomes[$];
   int fail_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_off_cycles = 0;
   int hold_left = 0;

   sequence_window_tracker u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic pkt_outcome_type classify_packet(input logic [SEQ_W-1:0] seq,
                                                       input logic restart);
      pkt_outcome_type res;
      logic [SEQ_W-1:0] delta;
      logic [SEQ_W-1:0] age;
      res.gap_lost = '0;
      if (restart) begin
         trk_valid = 1'b0;
         trk_highest = '0;
         trk_seen = '0;
      end
      if (!trk_valid) begin
         trk_valid = 1'b1;
         trk_highest = seq;
         trk_seen = WIN'(1);
         n_unique = n_unique + COUNT_W'(1);
         res.verdict = VERDICT_FIRST;
      end else begin
         delta = seq - trk_highest;
         // newer means a positive signed difference
         if (delta != '0 && !delta[SEQ_W-1]) begin
            res.gap_lost = GAP_W'(delta - SEQ_W'(1));
            n_lost = n_lost + COUNT_W'(delta - SEQ_W'(1));
            if (delta >= SEQ_W'(WIN))
               trk_seen = WIN'(1);
            else
               trk_seen = (trk_seen << delta) | WIN'(1);
            trk_highest = seq;
            n_unique = n_unique + COUNT_W'(1);
            res.verdict = VERDICT_NEWEST;
         end else begin
            age = trk_highest - seq;
            if (age < SEQ_W'(WIN)) begin
               if (trk_seen[age[WIN_IDX_W-1:0]]) begin
                  n_dup = n_dup + COUNT_W'(1);
                  res.verdict = VERDICT_DUPLICATE;
               end else begin
                  trk_seen[age[WIN_IDX_W-1:0]] = 1'b1;
                  n_late = n_late + COUNT_W'(1);
                  n_unique = n_unique + COUNT_W'(1);
                  res.verdict = VERDICT_LATE_FILL;
               end
            end else begin
               n_late = n_late + COUNT_W'(1);
               res.verdict = VERDICT_TOO_OLD;
            end
         end
      end
      res.unique_total = n_unique;
      res.lost_total   = n_lost;
      res.dup_total    = n_dup;
      res.late_total   = n_late;
      return res;
   endfunction

   // Entered just after a falling edge; returns just after the falling edge that follows acceptance.
   task automatic offer_packet(input logic [SEQ_W-1:0] seq, input logic restart);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= seq;
      req_tuser  <= restart;
      do @(posedge clock); while (!req_tready);
      pending_outcomes.push_back(classify_packet(seq, restart));
      @(negedge clock);
   endtask

   // receiver readiness, with an optional long hold-off
   always @(negedge clock) begin
      if (hold_off_cycles > 0) begin
         hold_left = hold_off_cycles;
         hold_off_cycles = 0;
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic check_field(input string name, input logic [COUNT_W-1:0] exp_val,
                              input logic [COUNT_W-1:0] act_val);
      if (act_val !== exp_val) begin
         $error("%s mismatch: expected %0h, got %0h", name, exp_val, act_val);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      pkt_outcome_type exp_res;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_outcomes.size() == 0) begin
            $error("response word with no packet outstanding");
            fail_count++;
         end else begin
            exp_res = pending_outcomes.pop_front();
            check_field("verdict", COUNT_W'(exp_res.verdict), COUNT_W'(rsp_tuser));
            check_field("gap_lost", COUNT_W'(exp_res.gap_lost), COUNT_W'(rsp_tdata[30:0]));
            check_field("unique_total", exp_res.unique_total, rsp_tdata[94:31]);
            check_field("lost_total", exp_res.lost_total, rsp_tdata[158:95]);
            check_field("duplicate_total", exp_res.dup_total, rsp_tdata[222:159]);
            check_field("late_total", exp_res.late_total, rsp_tdata[286:223]);
            check_field("pad", '0, COUNT_W'(rsp_tdata[287]));
         end
      end
   end

   // first word, restart, duplicate of the highest, advance across the wrap
   task automatic test_startup_and_wrap();
      offer_packet(32'hFFFF_FFF0, 1'b0);
      offer_packet(32'hFFFF_FFF0, 1'b0);
      offer_packet(32'hFFFF_FFF1, 1'b0);
      offer_packet(32'h0000_0004, 1'b0);
      offer_packet(32'hFFFF_FFF5, 1'b0);
      offer_packet(32'hFFFF_FFF5, 1'b0);
      offer_packet(32'hFFFF_FFFF, 1'b1);
      offer_packet(32'hFFFF_FFFF, 1'b1);
      offer_packet(32'h0000_0000, 1'b0);
   endtask

   // ages 63 and 64, advances of 127 and 65
   task automatic test_window_edges();
      offer_packet(32'h0000_1000, 1'b1);
      offer_packet(32'h0000_107F, 1'b0);
      offer_packet(32'h0000_1040, 1'b0);
      offer_packet(32'h0000_103F, 1'b0);
      offer_packet(32'h0000_10C0, 1'b0);
      offer_packet(32'h0000_1080, 1'b0);
      offer_packet(32'h0000_10BE, 1'b0);
   endtask

   // distance of exactly half the number space, largest legal gap
   task automatic test_half_range();
      offer_packet(32'h0000_0000, 1'b1);
      offer_packet(32'h8000_0000, 1'b0);
      offer_packet(32'h7FFF_FFFF, 1'b0);
      offer_packet(32'hFFFF_FFFF, 1'b0);
   endtask

   task automatic test_random_traffic(input int count);
      int pick;
      logic [SEQ_W-1:0] seq;
      logic restart;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         restart = 1'b0;
         if (pick < 55)
            seq = trk_highest + 1;
         else if (pick < 65)
            seq = trk_highest + $urandom_range(70, 2);
         else if (pick < 80)
            seq = trk_highest - $urandom_range(63, 1);
         else if (pick < 87)
            seq = trk_highest - $urandom_range(3, 0);
         else if (pick < 91)
            seq = trk_highest - $urandom_range(100000, 64);
         else if (pick < 94)
            seq = trk_highest + $urandom_range(32'h7FFF_FFFF, 71);
         else if (pick < 96) begin
            seq = $urandom;
            restart = 1'b1;
         end else
            seq = $urandom;
         offer_packet(seq, restart);
      end
   endtask

   // receiver stops for a long stretch while words keep coming
   task automatic test_backpressure();
      hold_off_cycles = 200;
      for (int i = 0; i < 40; i++)
         offer_packet(trk_highest + $urandom_range(3, 1), 1'b0);
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 21;
      recv_idle_pct = 65;
      test_startup_and_wrap();
      test_window_edges();
      test_half_range();
      test_random_traffic(560);

      send_idle_pct = 65;
      recv_idle_pct = 21;
      test_random_traffic(560);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_backpressure();
      test_random_traffic(560);

      req_tvalid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
